FILE: rtl/hbmfp_pkg.sv
// Shared types, codes and constants of the half blend pixel block.
`default_nettype none

package hbmfp_pkg;

    // Default depth of the palette store.
    localparam int PALETTE_ENTRIES_DEF = 256;

    // Configuration port geometry.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register index as decoded from paddr[2].
    localparam logic REG_PIXEL_FORMAT = 1'b0;

    // Operation codes of an input word.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_BLEND = 1'b1;

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Pixel format codes.
    typedef enum logic [2:0] {
        FMT_PAL = 3'd0,
        FMT_565 = 3'd1,
        FMT_555 = 3'd2,
        FMT_24  = 3'd3,
        FMT_32  = 3'd4
    } fmt_t;

    // Kind of work a command asks of the back end.
    typedef enum logic [1:0] {
        K_WRITE,
        K_PAL,
        K_DIRECT
    } kind_t;

    // Back end sequencer states.
    typedef enum logic [2:0] {
        BS_IDLE,
        BS_SRC,
        BS_DST,
        BS_SWEEP,
        BS_DONE
    } back_state_t;

    // One classified command.
    typedef struct packed {
        kind_t       kind;
        logic [2:0]  fmt;
        logic [7:0]  index;
        logic [23:0] rgb;
        logic [31:0] src;
        logic [31:0] dst;
    } cmd_t;

    // Queue status seen by front and back.
    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } q_stat_t;

endpackage

`default_nettype wire

FILE: rtl/hbmfp_ifs.sv
// Valid/ready channel interfaces for input words and result words.
`default_nettype none

interface hbmfp_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [7:0]  palette_index;
    logic [7:0]  entry_red;
    logic [7:0]  entry_green;
    logic [7:0]  entry_blue;
    logic [31:0] src_pixel;
    logic [31:0] dst_pixel;

    modport source (
        output valid, op, palette_index, entry_red, entry_green, entry_blue,
               src_pixel, dst_pixel,
        input  ready
    );
    modport sink (
        input  valid, op, palette_index, entry_red, entry_green, entry_blue,
               src_pixel, dst_pixel,
        output ready
    );
endinterface

interface hbmfp_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] blended_pixel;

    modport source (
        output valid, blended_pixel,
        input  ready
    );
    modport sink (
        input  valid, blended_pixel,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/hbmfp_front.sv
// Front end: configuration register and classification of input words.
`default_nettype none

module hbmfp_front (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    hbmfp_in_if.sink                                 in_ch,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [hbmfp_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [hbmfp_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [hbmfp_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                     pready,
    input  wire hbmfp_pkg::q_stat_t                  q_stat,
    output logic                                     q_push,
    output hbmfp_pkg::cmd_t                          q_cmd
);

    logic [2:0] fmt_reg;
    logic [2:0] fmt_next;
    logic       reg_wr;

    // Register write decode; pready is held high, so the access phase never waits.
    assign pready = 1'b1;
    assign reg_wr = psel && penable && pwrite && (paddr[2] == hbmfp_pkg::REG_PIXEL_FORMAT);

    always_comb
    begin
        fmt_next = fmt_reg;
        if (reg_wr)
        begin
            fmt_next = pwdata[2:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= hbmfp_pkg::FMT_PAL;
        end
        else
        begin
            fmt_reg <= fmt_next;
        end
    end

    // Register read mux.
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == hbmfp_pkg::REG_PIXEL_FORMAT)
        begin
            prdata = {{(hbmfp_pkg::APB_DATA_W-3){1'b0}}, fmt_reg};
        end
    end

    // Accept a word whenever the queue has room.
    assign in_ch.ready = !q_stat.full;
    assign q_push      = in_ch.valid && !q_stat.full;

    // Classify the word into the work the back end has to do.
    always_comb
    begin
        q_cmd.fmt   = fmt_reg;
        q_cmd.index = in_ch.palette_index;
        q_cmd.rgb   = {in_ch.entry_red, in_ch.entry_green, in_ch.entry_blue};
        q_cmd.src   = in_ch.src_pixel;
        q_cmd.dst   = in_ch.dst_pixel;
        if (in_ch.op == hbmfp_pkg::OP_WRITE)
        begin
            q_cmd.kind = hbmfp_pkg::K_WRITE;
        end
        else if (fmt_reg == hbmfp_pkg::FMT_PAL)
        begin
            q_cmd.kind = hbmfp_pkg::K_PAL;
        end
        else
        begin
            q_cmd.kind = hbmfp_pkg::K_DIRECT;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/hbmfp_queue.sv
// Short command queue between the front end and the back end.
`default_nettype none

module hbmfp_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire hbmfp_pkg::cmd_t    wdata,
    input  wire logic               pop,
    output hbmfp_pkg::cmd_t         head,
    output hbmfp_pkg::q_stat_t      stat
);

    hbmfp_pkg::cmd_t                   slot_reg [hbmfp_pkg::QUEUE_DEPTH];
    logic [hbmfp_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [hbmfp_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [hbmfp_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [hbmfp_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [hbmfp_pkg::QCNT_W-1:0]      count_reg;
    logic [hbmfp_pkg::QCNT_W-1:0]      count_next;

    assign head       = slot_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == hbmfp_pkg::QCNT_W'(hbmfp_pkg::QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.count = count_reg;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/hbmfp_back.sv
// Back end: palette store, direct blends and the nearest-color sweep.
`default_nettype none

module hbmfp_back #(
    parameter int PALETTE_ENTRIES = hbmfp_pkg::PALETTE_ENTRIES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire hbmfp_pkg::cmd_t    head,
    input  wire hbmfp_pkg::q_stat_t q_stat,
    output logic                    pop,
    hbmfp_out_if.source             out_ch
);

    localparam int IDX_W = $clog2(PALETTE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);

    // Average of two unsigned channels, rounded down.
    function automatic logic [4:0] avg5(input logic [4:0] a, input logic [4:0] b);
        logic [5:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[5:1];
    endfunction

    function automatic logic [5:0] avg6(input logic [5:0] a, input logic [5:0] b);
        logic [6:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[6:1];
    endfunction

    function automatic logic [7:0] avg8(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[8:1];
    endfunction

    function automatic logic [7:0] absd(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Direct-color blend for the 565, 555, 24 and 32-bit format codes; any other code gives zero.
    function automatic logic [31:0] blend_direct(input logic [2:0] fmt,
                                                 input logic [31:0] s,
                                                 input logic [31:0] d);
        logic [31:0] res;
        res = '0;
        case (fmt)
            hbmfp_pkg::FMT_565:
            begin
                res = {16'd0, avg5(s[15:11], d[15:11]), avg6(s[10:5], d[10:5]),
                       avg5(s[4:0], d[4:0])};
            end
            hbmfp_pkg::FMT_555:
            begin
                res = {17'd0, avg5(s[14:10], d[14:10]), avg5(s[9:5], d[9:5]),
                       avg5(s[4:0], d[4:0])};
            end
            hbmfp_pkg::FMT_24, hbmfp_pkg::FMT_32:
            begin
                res = {8'd0, avg8(s[23:16], d[23:16]), avg8(s[15:8], d[15:8]),
                       avg8(s[7:0], d[7:0])};
            end
            default:
            begin
                res = '0;
            end
        endcase
        return res;
    endfunction

    // Palette storage with one write port and one registered read port.
    logic [23:0]                mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] valid_reg;
    logic [23:0]                rd_data_reg;
    logic                       rd_valid_reg;
    logic                       rd_zero_reg;
    logic                       rd_zero_next;
    logic [IDX_W-1:0]           rd_addr;
    logic                       mem_we;
    logic [IDX_W-1:0]           wr_addr;

    hbmfp_pkg::back_state_t     state_reg;
    hbmfp_pkg::back_state_t     state_next;
    logic [IDX_W-1:0]           cnt_reg;
    logic [IDX_W-1:0]           cnt_next;
    logic [IDX_W-1:0]           best_idx_reg;
    logic [IDX_W-1:0]           best_idx_next;
    logic [9:0]                 best_err_reg;
    logic [9:0]                 best_err_next;
    logic [23:0]                cs_reg;
    logic [23:0]                cs_next;
    logic [23:0]                avg_reg;
    logic [23:0]                avg_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [31:0]                out_data_reg;
    logic [31:0]                out_data_next;

    logic                       out_free;
    logic [23:0]                ent;
    logic [9:0]                 err;
    logic                       head_in_range;
    logic [IDX_W-1:0]           src_addr;
    logic                       src_zero;
    logic [IDX_W-1:0]           dst_addr;
    logic                       dst_zero;

    assign out_free = !out_valid_reg || out_ch.ready;

    // Entry color seen this cycle; never-written or out-of-range reads as zero.
    assign ent = (rd_valid_reg && !rd_zero_reg) ? rd_data_reg : 24'd0;

    // Sum of absolute channel differences against the averaged color.
    assign err = 10'(absd(avg_reg[23:16], ent[23:16]))
               + 10'(absd(avg_reg[15:8], ent[15:8]))
               + 10'(absd(avg_reg[7:0], ent[7:0]));

    // Index range checks for palette writes and pixel reads.
    assign head_in_range = (9'(head.index) < 9'(PALETTE_ENTRIES));
    assign wr_addr       = head_in_range ? head.index[IDX_W-1:0] : '0;
    assign src_zero      = !(9'(head.src[7:0]) < 9'(PALETTE_ENTRIES));
    assign src_addr      = src_zero ? '0 : head.src[IDX_W-1:0];
    assign dst_zero      = !(9'(head.dst[7:0]) < 9'(PALETTE_ENTRIES));
    assign dst_addr      = dst_zero ? '0 : head.dst[IDX_W-1:0];

    // Sequencer: next state, memory control and result loading.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        best_idx_next  = best_idx_reg;
        best_err_next  = best_err_reg;
        cs_next        = cs_reg;
        avg_next       = avg_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_data_next  = out_data_reg;
        pop            = 1'b0;
        mem_we         = 1'b0;
        rd_addr        = '0;
        rd_zero_next   = 1'b0;
        case (state_reg)
            hbmfp_pkg::BS_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    case (head.kind)
                        hbmfp_pkg::K_WRITE:
                        begin
                            mem_we = head_in_range;
                            pop    = 1'b1;
                        end
                        hbmfp_pkg::K_DIRECT:
                        begin
                            if (out_free)
                            begin
                                out_valid_next = 1'b1;
                                out_data_next  = blend_direct(head.fmt, head.src, head.dst);
                                pop            = 1'b1;
                            end
                        end
                        hbmfp_pkg::K_PAL:
                        begin
                            rd_addr      = src_addr;
                            rd_zero_next = src_zero;
                            state_next   = hbmfp_pkg::BS_SRC;
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            hbmfp_pkg::BS_SRC:
            begin
                cs_next      = ent;
                rd_addr      = dst_addr;
                rd_zero_next = dst_zero;
                state_next   = hbmfp_pkg::BS_DST;
            end
            hbmfp_pkg::BS_DST:
            begin
                avg_next   = {avg8(cs_reg[23:16], ent[23:16]), avg8(cs_reg[15:8], ent[15:8]),
                              avg8(cs_reg[7:0], ent[7:0])};
                rd_addr    = '0;
                cnt_next   = '0;
                state_next = hbmfp_pkg::BS_SWEEP;
            end
            hbmfp_pkg::BS_SWEEP:
            begin
                // The first entry always beats the start value; ties keep the lower index.
                if ((cnt_reg == '0) || (err < best_err_reg))
                begin
                    best_err_next = err;
                    best_idx_next = cnt_reg;
                end
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next   = '0;
                    state_next = hbmfp_pkg::BS_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                rd_addr = cnt_next;
            end
            hbmfp_pkg::BS_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = 32'(best_idx_reg);
                    pop            = 1'b1;
                    state_next     = hbmfp_pkg::BS_IDLE;
                end
            end
            default:
            begin
                state_next = hbmfp_pkg::BS_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hbmfp_pkg::BS_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (mem_we)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        best_idx_reg <= best_idx_next;
        best_err_reg <= best_err_next;
        cs_reg       <= cs_next;
        avg_reg      <= avg_next;
        out_data_reg <= out_data_next;
        rd_zero_reg  <= rd_zero_next;
    end

    // Palette memory.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= head.rgb;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.blended_pixel = out_data_reg;

endmodule

`default_nettype wire

FILE: rtl/half_blend_multi_format_pixel.sv
// Top level of the fifty percent pixel blend with palette nearest color.
//
// Input words arrive on in_ch (valid/ready). A word with op 0 writes one
// palette entry and gives no result; a word with op 1 blends src_pixel and
// dst_pixel in the format held in the pixel_format register and gives one
// result word on out_ch (valid/ready). The register sits at APB address 0.
// The front end takes a word into a two-entry command queue in the cycle it
// is offered, as long as the queue has room. The back end then runs one
// command at a time: a palette write or a direct-color blend is done from
// the idle state; a paletted blend reads the source entry, reads the
// destination entry, sweeps all PALETTE_ENTRIES entries and ends in a done
// state, its length set by the single read port of the palette memory that
// is swept one entry a cycle. An accepted word is first held in a queue
// slot; its result is loaded into the output register at the edge that ends
// its command. When out_ch stalls, the result holds in the output register,
// the back end waits with its next result, and the queue fills before
// in_ch deasserts ready. Reset clears the queue, the output valid flag, the
// format register (paletted) and the valid bits of the palette, so every
// entry reads as black until written; no clearing pass is needed.
`default_nettype none

module half_blend_multi_format_pixel #(
    parameter int PALETTE_ENTRIES = hbmfp_pkg::PALETTE_ENTRIES_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    hbmfp_in_if.sink                                 in_ch,
    hbmfp_out_if.source                              out_ch,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [hbmfp_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [hbmfp_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [hbmfp_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                     pready
);

    hbmfp_pkg::q_stat_t q_stat;
    hbmfp_pkg::cmd_t    q_cmd;
    hbmfp_pkg::cmd_t    q_head;
    logic               q_push;
    logic               q_pop;

    // Front end: register port and classification.
    hbmfp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .q_stat  (q_stat),
        .q_push  (q_push),
        .q_cmd   (q_cmd)
    );

    // Command queue.
    hbmfp_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_cmd),
        .pop   (q_pop),
        .head  (q_head),
        .stat  (q_stat)
    );

    // Back end: palette, blends and search.
    hbmfp_back #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (q_head),
        .q_stat (q_stat),
        .pop    (q_pop),
        .out_ch (out_ch)
    );

`ifndef SYNTHESIS
    // The front end never pushes into a full queue.
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("command pushed into full queue");

    // The back end never pops an empty queue.
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("command popped from empty queue");

    // The fill count rises by one on a push without a pop.
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && !q_pop) |=> (q_stat.count == $past(q_stat.count) + 1'b1))
        else $error("queue count did not advance on push");
`endif

endmodule

`default_nettype wire
